// ===== src/bsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;

    localparam int MAX_NODES = 1024;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int POS_W     = IDX_W + 1;
    localparam int VAR_W     = 6;
    localparam int CNT_W     = 64;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [VAR_W-1:0] t_var;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        t_var node_var;
        t_cnt count;
    } t_entry;

    // node in flight between the read issue and the evaluation
    typedef struct packed {
        t_pos pos;
        t_var node_var;
        t_idx lo;
        t_idx hi;
        logic last;
        logic sink0;
        logic sink1;
        logic cap_bad;
        logic order_bad;
    } t_stage;

    // most recent store write, for forwarding
    typedef struct packed {
        logic   valid;
        t_idx   idx;
        t_entry entry;
    } t_wb;

    typedef struct packed {
        t_idx idx;
        t_var node_var;
        t_cnt count;
        logic sat;
        logic bad;
        logic last;
        logic wr_en;
    } t_result;

endpackage
`default_nettype wire

// ===== src/bsc_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bsc_store (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire bsc_pkg::t_idx   i_waddr,
    input  wire bsc_pkg::t_entry i_wdata,
    input  wire logic            i_re,
    input  wire bsc_pkg::t_idx   i_raddr_a,
    input  wire bsc_pkg::t_idx   i_raddr_b,
    output bsc_pkg::t_entry      o_rdata_a,
    output bsc_pkg::t_entry      o_rdata_b
);

    bsc_pkg::t_entry mem [bsc_pkg::MAX_NODES];
    bsc_pkg::t_entry r_rdata_a;
    bsc_pkg::t_entry r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while the evaluation stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= mem[i_raddr_a];
            r_rdata_b <= mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
`default_nettype wire

// ===== src/bsc_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bsc_eval (
    input  wire bsc_pkg::t_stage i_stage,
    input  wire bsc_pkg::t_entry i_rdata_a,
    input  wire bsc_pkg::t_entry i_rdata_b,
    input  wire bsc_pkg::t_wb    i_wb,
    output bsc_pkg::t_result     o_res
);

    bsc_pkg::t_entry ent_lo;
    bsc_pkg::t_entry ent_hi;
    bsc_pkg::t_var   e_lo;
    bsc_pkg::t_var   e_hi;
    logic            var_bad;
    logic            ovf_lo;
    logic            ovf_hi;
    bsc_pkg::t_cnt   term_lo;
    bsc_pkg::t_cnt   term_hi;
    logic [bsc_pkg::CNT_W:0] sum;
    bsc_pkg::t_cnt   cnt;
    logic            sat;

    always_comb begin
        // the store misses the write that lands on the same edge as the read
        ent_lo = (i_wb.valid && (i_wb.idx == i_stage.lo)) ? i_wb.entry : i_rdata_a;
        ent_hi = (i_wb.valid && (i_wb.idx == i_stage.hi)) ? i_wb.entry : i_rdata_b;

        var_bad = (ent_lo.node_var <= i_stage.node_var)
               || (ent_hi.node_var <= i_stage.node_var);

        e_lo = ent_lo.node_var - i_stage.node_var - bsc_pkg::VAR_W'(1);
        e_hi = ent_hi.node_var - i_stage.node_var - bsc_pkg::VAR_W'(1);

        // any bit above the room left after the shift means clamping
        ovf_lo  = |(ent_lo.count & ~(bsc_pkg::CNT_MAX >> e_lo));
        ovf_hi  = |(ent_hi.count & ~(bsc_pkg::CNT_MAX >> e_hi));
        term_lo = ovf_lo ? bsc_pkg::CNT_MAX : (ent_lo.count << e_lo);
        term_hi = ovf_hi ? bsc_pkg::CNT_MAX : (ent_hi.count << e_hi);

        sum = {1'b0, term_lo} + {1'b0, term_hi};
        cnt = sum[bsc_pkg::CNT_W] ? bsc_pkg::CNT_MAX : sum[bsc_pkg::CNT_W-1:0];
        sat = ovf_lo || ovf_hi || sum[bsc_pkg::CNT_W];

        o_res.idx      = i_stage.pos[bsc_pkg::IDX_W-1:0];
        o_res.node_var = i_stage.node_var;
        o_res.last     = i_stage.last;
        o_res.wr_en    = !i_stage.cap_bad;
        o_res.count    = '0;
        o_res.sat      = 1'b0;
        o_res.bad      = 1'b0;

        if (i_stage.cap_bad) begin
            o_res.bad = 1'b1;
        end else if (i_stage.sink0) begin
            o_res.count = '0;
        end else if (i_stage.sink1) begin
            o_res.count = bsc_pkg::CNT_W'(1);
        end else if (i_stage.order_bad || var_bad) begin
            o_res.bad = 1'b1;
        end else begin
            o_res.count = cnt;
            o_res.sat   = sat;
        end
    end

endmodule
`default_nettype wire

// ===== src/bdd_solution_counter_top.sv =====
// path: beat and store reads registered, then the result registered at the output
// throughput: one node per cycle unless the output stalls, set by the combinational
//   shift, add and clamp loop that feeds each count straight to the next node
// reset: synchronous, active low; clears the position, the pipeline valids
//   and the forwarding entry; the node store is not cleared
`timescale 1ns / 1ps
`default_nettype none
module bdd_solution_counter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // node_var[5:0], lo_child[15:6], hi_child[25:16]
    input  wire logic        s_axis_tlast,  // last_node
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,  // node_index[9:0], solution_count[73:10]
    output logic [1:0]       m_axis_tuser,  // saturated[0], bad_node[1]
    output logic             m_axis_tlast   // final_res
);

    logic                in_fire;
    logic                s1_move;
    bsc_pkg::t_pos       r_pos;
    bsc_pkg::t_pos       n_pos;
    logic                r_s1_valid;
    bsc_pkg::t_stage     r_s1;
    bsc_pkg::t_stage     n_s1;
    bsc_pkg::t_wb        r_wb;
    logic                r_out_valid;
    bsc_pkg::t_result    r_out;
    bsc_pkg::t_result    res;
    bsc_pkg::t_entry     rdata_a;
    bsc_pkg::t_entry     rdata_b;
    bsc_pkg::t_entry     wdata;
    bsc_pkg::t_var       in_var;
    bsc_pkg::t_idx       in_lo;
    bsc_pkg::t_idx       in_hi;

    assign in_var = s_axis_tdata[5:0];
    assign in_lo  = s_axis_tdata[15:6];
    assign in_hi  = s_axis_tdata[25:16];

    assign s1_move       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_move;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_s1.pos       = r_pos;
        n_s1.node_var  = in_var;
        n_s1.lo        = in_lo;
        n_s1.hi        = in_hi;
        n_s1.last      = s_axis_tlast;
        n_s1.sink0     = (r_pos == bsc_pkg::POS_W'(0));
        n_s1.sink1     = (r_pos == bsc_pkg::POS_W'(1));
        n_s1.cap_bad   = (r_pos >= bsc_pkg::POS_W'(bsc_pkg::MAX_NODES));
        n_s1.order_bad = ({1'b0, in_lo} >= r_pos) || ({1'b0, in_hi} >= r_pos);

        n_pos = r_pos;
        if (s_axis_tlast) begin
            n_pos = '0;
        end else if (!n_s1.cap_bad) begin
            n_pos = r_pos + bsc_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wb.valid  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_pos      <= n_pos;
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (s1_move && res.wr_en) begin
                r_wb.valid <= 1'b1;
                r_wb.idx   <= res.idx;
                r_wb.entry <= wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_out <= res;
        end
    end

    assign wdata.node_var = res.node_var;
    assign wdata.count    = res.count;

    bsc_store u_store (
        .i_clk     (i_clk),
        .i_we      (s1_move && res.wr_en),
        .i_waddr   (res.idx),
        .i_wdata   (wdata),
        .i_re      (in_fire),
        .i_raddr_a (in_lo),
        .i_raddr_b (in_hi),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    bsc_eval u_eval (
        .i_stage   (r_s1),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .i_wb      (r_wb),
        .o_res     (res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.count, r_out.idx};
    assign m_axis_tuser  = {r_out.bad, r_out.sat};
    assign m_axis_tlast  = r_out.last;

endmodule
`default_nettype wire

// ===== src/bsc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bsc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [79:0] i_m_tdata,
    input wire logic [1:0]  i_m_tuser,
    input wire logic        i_m_tlast
);

    // stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast))
        else $error("result beat changed while stalled");

    // a flagged node carries count zero
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[1] |-> i_m_tdata[73:10] == 64'd0)
        else $error("bad node with non-zero count");

    // clamping only happens on a well-formed node
    a_sat_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[0] |-> !i_m_tuser[1])
        else $error("saturated and bad together");

    // a clamped count is all ones
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser[0] |-> i_m_tdata[73:10] == {64{1'b1}})
        else $error("saturated count not at maximum");

endmodule

bind bdd_solution_counter_top bsc_checker u_bsc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser),
    .i_m_tlast  (m_axis_tlast)
);
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

    localparam int RANDOM_NODES    = 2000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int STALL_LIMIT     = 2000;

    typedef struct {
        bsc_pkg::t_var node_var;
        bsc_pkg::t_idx lo;
        bsc_pkg::t_idx hi;
        logic          last;
    } t_node_beat;

    typedef struct packed {
        bsc_pkg::t_idx idx;
        bsc_pkg::t_cnt count;
        logic          sat;
        logic          bad;
        logic          last;
    } t_node_count;

    class count_board;
        bsc_pkg::t_var var_mem[bsc_pkg::MAX_NODES];
        bsc_pkg::t_cnt count_mem[bsc_pkg::MAX_NODES];
        int unsigned   pos;
        t_node_count   expected_counts[$];
        int            mismatches;
        int            counts_checked;
        int            bad_seen;
        int            overruns;

        function bsc_pkg::t_cnt shift_clamped(bsc_pkg::t_cnt c, int unsigned e, inout logic sat);
            if (c != 0 && c > (bsc_pkg::CNT_MAX >> e)) begin
                sat = 1'b1;
                return bsc_pkg::CNT_MAX;
            end
            return c << e;
        endfunction

        function bsc_pkg::t_cnt add_clamped(bsc_pkg::t_cnt a, bsc_pkg::t_cnt b, inout logic sat);
            if (a > bsc_pkg::CNT_MAX - b) begin
                sat = 1'b1;
                return bsc_pkg::CNT_MAX;
            end
            return a + b;
        endfunction

        // works out the count of one accepted node and queues it
        function void count_node(t_node_beat nb);
            t_node_count   r;
            bsc_pkg::t_cnt a;
            bsc_pkg::t_cnt b;
            logic          sat;
            int unsigned   lo_var;
            int unsigned   hi_var;
            r = '0;
            sat = 1'b0;
            r.idx = pos[bsc_pkg::IDX_W-1:0];
            r.last = nb.last;
            if (pos >= bsc_pkg::MAX_NODES) begin
                r.bad = 1'b1;
                overruns++;
            end else begin
                if (pos == 1) begin
                    r.count = bsc_pkg::t_cnt'(1);
                end else if (pos >= 2) begin
                    if (nb.lo >= pos || nb.hi >= pos) begin
                        r.bad = 1'b1;
                    end else begin
                        lo_var = var_mem[nb.lo];
                        hi_var = var_mem[nb.hi];
                        if (lo_var <= nb.node_var || hi_var <= nb.node_var) begin
                            r.bad = 1'b1;
                        end else begin
                            a = shift_clamped(count_mem[nb.lo], lo_var - nb.node_var - 1, sat);
                            b = shift_clamped(count_mem[nb.hi], hi_var - nb.node_var - 1, sat);
                            r.count = add_clamped(a, b, sat);
                        end
                    end
                end
                var_mem[pos] = nb.node_var;
                count_mem[pos] = r.count;
            end
            r.sat = sat;
            if (r.bad) bad_seen++;
            expected_counts.insert(expected_counts.size(), r);
            if (nb.last) begin
                pos = 0;
            end else if (pos < bsc_pkg::MAX_NODES) begin
                pos++;
            end
        endfunction

        function void check_result(t_node_count got);
            t_node_count want;
            if (expected_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("count beat with nothing pending: node %0d count %0h sat %0b bad %0b",
                             got.idx, got.count, got.sat, got.bad);
                end
                return;
            end
            want = expected_counts.pop_front();
            counts_checked++;
            if (got.idx !== want.idx || got.count !== want.count || got.sat !== want.sat ||
                got.bad !== want.bad || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("expected node %0d count %0h sat %0b bad %0b last %0b",
                             want.idx, want.count, want.sat, want.bad, want.last);
                    $display("     got node %0d count %0h sat %0b bad %0b last %0b",
                             got.idx, got.count, got.sat, got.bad, got.last);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // node_var[5:0], lo_child[15:6], hi_child[25:16]
    logic        s_axis_tlast;   // last_node
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // node_index[9:0], solution_count[73:10]
    logic [1:0]  m_axis_tuser;   // saturated[0], bad_node[1]
    logic        m_axis_tlast;   // final_res

    count_board    board = new();
    t_node_beat    node_stream[$];
    bsc_pkg::t_var gen_var[bsc_pkg::MAX_NODES];
    int unsigned   gen_pos = 0;
    int unsigned   filled_to = 0;
    int            idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    bdd_solution_counter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // mirrors the position and levels so the generator knows what is legal
    function automatic void add_node(int v, int lo, int hi, bit last);
        t_node_beat nb;
        nb.node_var = bsc_pkg::t_var'(v);
        nb.lo = bsc_pkg::t_idx'(lo);
        nb.hi = bsc_pkg::t_idx'(hi);
        nb.last = last;
        node_stream.insert(node_stream.size(), nb);
        if (gen_pos < bsc_pkg::MAX_NODES) begin
            gen_var[gen_pos] = nb.node_var;
            if (gen_pos >= filled_to) filled_to = gen_pos + 1;
        end
        if (last) begin
            gen_pos = 0;
        end else if (gen_pos < bsc_pkg::MAX_NODES) begin
            gen_pos++;
        end
    endfunction

    // earlier in this diagram, its own position, or an entry that already holds data
    function automatic int reachable_idx();
        int top_idx;
        top_idx = (filled_to > gen_pos) ? filled_to : gen_pos + 1;
        if (top_idx > bsc_pkg::MAX_NODES) top_idx = bsc_pkg::MAX_NODES;
        return $urandom_range(0, top_idx - 1);
    endfunction

    // at or beyond the node's own position, so the child order is broken
    function automatic int forward_idx();
        int top_idx;
        top_idx = (filled_to > gen_pos + 1) ? filled_to - 1 : gen_pos;
        return $urandom_range(gen_pos, top_idx);
    endfunction

    function automatic void add_diagram(int n_nodes, int mutate_pct);
        int sink_var;
        int lo;
        int hi;
        int tmp;
        int low_var;
        int v;
        bit last;
        sink_var = ($urandom_range(0, 9) < 7) ? 63 : $urandom_range(1, 63);
        for (int p = 0; p < n_nodes; p++) begin
            last = (p == n_nodes - 1);
            if (p < 2) begin
                add_node(sink_var, reachable_idx(), reachable_idx(), last);
            end else if (p >= bsc_pkg::MAX_NODES) begin
                add_node($urandom_range(0, 63), $urandom_range(0, bsc_pkg::MAX_NODES - 1),
                         $urandom_range(0, bsc_pkg::MAX_NODES - 1), last);
            end else begin
                // lean on recent nodes so the chains get deep
                if ($urandom_range(0, 9) < 6) begin
                    lo = $urandom_range(p - 2, p - 1);
                    hi = $urandom_range(0, p - 1);
                end else begin
                    lo = $urandom_range(0, p - 1);
                    hi = $urandom_range(0, p - 1);
                end
                if ($urandom_range(0, 1)) begin
                    tmp = lo;
                    lo = hi;
                    hi = tmp;
                end
                low_var = (gen_var[lo] < gen_var[hi]) ? gen_var[lo] : gen_var[hi];
                if (low_var == 0) begin
                    lo = 1;
                    hi = $urandom_range(0, 1) ? 1 : lo;
                    low_var = gen_var[1];
                end
                if ($urandom_range(0, 9) < 3) begin
                    v = $urandom_range(0, low_var - 1);
                end else begin
                    v = low_var - 1 - $urandom_range(0, (low_var > 4) ? 3 : low_var - 1);
                end
                if ($urandom_range(0, 99) < mutate_pct) begin
                    case ($urandom_range(0, 2))
                        0: lo = forward_idx();
                        1: hi = forward_idx();
                        default: v = $urandom_range(low_var, 63);
                    endcase
                end
                add_node(v, lo, hi, last);
            end
        end
    endfunction

    function automatic void add_noise(int n_nodes);
        for (int p = 0; p < n_nodes; p++) begin
            add_node($urandom_range(0, 63), reachable_idx(), reachable_idx(), p == n_nodes - 1);
        end
    endfunction

    function automatic void build_stimulus();
        int directed_n;
        // sink 0 alone ends its diagram
        add_node(63, 0, 0, 1);
        add_node(63, 0, 0, 0);
        add_node(63, 0, 0, 0);
        add_node(0, 0, 1, 0);       // 2^62
        add_node(0, 1, 1, 0);       // 2^63, the largest count six-bit levels allow
        add_node(62, 1, 1, 0);
        add_node(61, 4, 4, 0);
        add_node(5, 6, 0, 0);       // low child is the node itself
        add_node(5, 1, 8, 0);       // high child further on
        add_node(63, 1, 1, 0);      // same level as its children
        add_node(62, 7, 1, 0);      // child was stored as bad with a lower level
        add_node(0, 7, 5, 0);       // zero count from a bad child plus a shifted term
        add_node(2, 3, 2, 0);       // children at level 0 under level 2
        add_node(63, 10, 10, 1);    // bad node closes the diagram
        // sinks at level 0: nothing above them can be ordered
        add_node(0, 0, 0, 0);
        add_node(0, 0, 0, 0);
        add_node(0, 0, 1, 1);
        // diagram that ends on sink 1
        add_node(40, 0, 0, 0);
        add_node(40, 0, 0, 1);
        directed_n = node_stream.size();

        // one diagram runs past the store, which also fills every entry
        add_diagram(bsc_pkg::MAX_NODES + 6, 2);
        while (node_stream.size() < directed_n + RANDOM_NODES) begin
            if ($urandom_range(0, 4) != 0) begin
                add_diagram($urandom_range(1, 40), 8);
            end else begin
                add_noise($urandom_range(1, 20));
            end
        end
    endfunction

    task automatic send_nodes();
        int gap;
        foreach (node_stream[k]) begin
            gap = ((k / 64) % 3 == 0) ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {6'b0, node_stream[k].hi, node_stream[k].lo, node_stream[k].node_var};
            s_axis_tlast  <= node_stream[k].last;
            do @(posedge i_clk); while (!s_axis_tready);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic take_counts();
        int stall;
        int beats;
        beats = 0;
        forever begin
            stall = ((beats / 64) % 3 == 1) ? 0 : $urandom_range(0, 5);
            // long hold-off so the block backs up into its input
            if (beats == 300) stall = HOLD_OFF_CYCLES;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            beats++;
        end
    endtask

    always @(posedge i_clk) begin
        t_node_beat  nb;
        t_node_count got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                nb.node_var = s_axis_tdata[5:0];
                nb.lo = s_axis_tdata[15:6];
                nb.hi = s_axis_tdata[25:16];
                nb.last = s_axis_tlast;
                board.count_node(nb);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.idx = m_axis_tdata[9:0];
                got.count = m_axis_tdata[73:10];
                got.sat = m_axis_tuser[0];
                got.bad = m_axis_tuser[1];
                got.last = m_axis_tlast;
                board.check_result(got);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("no beat moved for %0d cycles", STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        build_stimulus();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            take_counts();
        join_none
        send_nodes();
        while (board.expected_counts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        $display("%0d node beats sent, %0d counts checked, %0d bad nodes, %0d past capacity",
                 node_stream.size(), board.counts_checked, board.bad_seen, board.overruns);
        $display("%0d mismatches", board.mismatches);
        if (board.mismatches == 0 && board.expected_counts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
